[rtl/sard_pkg.sv]
package sard_pkg;

  localparam int SLOTS      = 1024;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int MARK_W     = SLOT_W + 1;
  localparam int FRAME_W    = 31;
  localparam int DELAY_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SLOT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_DELAY    = 2'd3;

  localparam logic [SLOT_W-1:0]  RST_FIRST_SLOT     = SLOT_W'(1);
  localparam logic [MARK_W-1:0]  RST_SLOT_LIMIT     = MARK_W'(1024);
  localparam logic [DELAY_W-1:0] RST_STARTUP_WINDOW = DELAY_W'(20);
  localparam logic [DELAY_W-1:0] RST_REUSE_DELAY    = DELAY_W'(5);

  typedef enum logic [2:0] {
    ST_REUSED   = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_FREED    = 3'd3,
    ST_BAD_FREE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_EXEC,
    FSM_SCAN,
    FSM_GROW,
    FSM_RESULT
  } fsm_t;

endpackage

[rtl/slot_allocator_reuse_delay.sv]
// Slot allocator with reuse quarantine over a 1024-entry table. Each request
// gives exactly one result item. A free is checked and, if in range, written
// in the exec state. An allocate scans the table one slot per cycle from
// first_slot up to the high-water mark through the single read port of the
// slot tables, testing each slot with one shared age compare. A reuse hit
// ends the scan; with no reusable slot the grow state takes the slot at the
// mark or reports a full table. The next item can be taken in the same cycle
// as the result appears. One request is worked on at a time; in_stall stays
// high until its result is handed to the output register, which then waits
// for the sink while the next item is taken. After reset the used-bit table
// is cleared in a pass over all 1024 slots, during which no item is accepted
// (configuration writes are taken). Configuration must only be written while
// the block is idle.
module slot_allocator_reuse_delay (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [sard_pkg::SLOT_W-1:0]   in_slot_index,
  input  logic [sard_pkg::FRAME_W-1:0]  in_frame,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sard_pkg::SLOT_W-1:0]   out_granted_slot,
  output logic [2:0]                    out_status,
  // configuration write port
  input  logic                          cfg_wr_en,
  input  logic [sard_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sard_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sard_pkg::*;

  // configuration registers
  logic [SLOT_W-1:0]  first_slot_r;
  logic [MARK_W-1:0]  slot_limit_r;
  logic [DELAY_W-1:0] startup_window_r;
  logic [DELAY_W-1:0] reuse_delay_r;

  // sequencer and latched item
  fsm_t               state_r, state_nxt;
  logic               action_r;
  logic [SLOT_W-1:0]  idx_r;
  logic [FRAME_W-1:0] frame_r;
  logic [MARK_W-1:0]  high_water_r, high_water_nxt;
  logic [SLOT_W-1:0]  clr_r;

  // scan pipeline: address issue, then registered read data checked
  logic [MARK_W-1:0]  scan_r, scan_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [SLOT_W-1:0]  chk_idx_r, chk_idx_nxt;

  // pending result and output register
  logic [SLOT_W-1:0]  res_slot_r, res_slot_nxt;
  status_t            res_status_r, res_status_nxt;
  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  status_t            out_status_r;

  // slot tables
  logic               used_mem [SLOTS];
  logic [FRAME_W-1:0] time_mem [SLOTS];
  logic               used_q_r;
  logic [FRAME_W-1:0] time_q_r;
  logic               used_we, used_wd;
  logic [SLOT_W-1:0]  used_wa;
  logic               time_we;
  logic [SLOT_W-1:0]  rd_addr;

  logic [MARK_W-1:0]  mark;
  logic               in_acc, out_load;
  logic               bad_free, table_full, clr_last;
  logic [FRAME_W:0]   age;
  logic               may_reuse, hit;

  // effective high-water mark: never below first_slot
  assign mark = (high_water_r < {1'b0, first_slot_r}) ? {1'b0, first_slot_r} : high_water_r;

  assign in_stall = (state_r != FSM_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state_r == FSM_RESULT) && (!out_valid_r || !out_stall);
  assign clr_last = (clr_r == SLOT_W'(SLOTS - 1));

  assign bad_free   = (idx_r < first_slot_r) || ({1'b0, idx_r} >= mark);
  assign table_full = (mark >= slot_limit_r) || (mark >= MARK_W'(SLOTS));

  // shared reuse test: startup window, or signed age beyond the delay
  assign age       = {1'b0, frame_r} - {1'b0, time_q_r};
  assign may_reuse = (time_q_r < FRAME_W'(startup_window_r)) ||
                     (!age[FRAME_W] && (age[FRAME_W-1:0] > FRAME_W'(reuse_delay_r)));
  assign hit       = chk_vld_r && !used_q_r && may_reuse;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_slot_r     <= RST_FIRST_SLOT;
      slot_limit_r     <= RST_SLOT_LIMIT;
      startup_window_r <= RST_STARTUP_WINDOW;
      reuse_delay_r    <= RST_REUSE_DELAY;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FIRST_SLOT:     first_slot_r     <= cfg_wdata[SLOT_W-1:0];
        CFG_SLOT_LIMIT:     slot_limit_r     <= cfg_wdata[MARK_W-1:0];
        CFG_STARTUP_WINDOW: startup_window_r <= cfg_wdata[DELAY_W-1:0];
        CFG_REUSE_DELAY:    reuse_delay_r    <= cfg_wdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_CLEAR: if (clr_last) state_nxt = FSM_IDLE;
      FSM_IDLE:  if (in_acc) state_nxt = FSM_EXEC;
      FSM_EXEC: begin
        if (action_r) begin
          state_nxt = FSM_RESULT;
        end else if ({1'b0, first_slot_r} < mark) begin
          state_nxt = FSM_SCAN;
        end else begin
          state_nxt = FSM_GROW;
        end
      end
      FSM_SCAN: begin
        priority if (hit) begin
          state_nxt = FSM_RESULT;
        end else if (scan_r >= mark) begin
          // last candidate checked, none reusable
          state_nxt = FSM_GROW;
        end
      end
      FSM_GROW:   state_nxt = FSM_RESULT;
      FSM_RESULT: if (out_load) state_nxt = FSM_IDLE;
      default:    state_nxt = FSM_CLEAR;
    endcase
  end

  // datapath controls
  always_comb begin
    scan_nxt       = scan_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    high_water_nxt = high_water_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    used_we        = 1'b0;
    used_wa        = idx_r;
    used_wd        = 1'b0;
    time_we        = 1'b0;
    rd_addr        = scan_r[SLOT_W-1:0];
    unique case (state_r)
      FSM_CLEAR: begin
        used_we = 1'b1;
        used_wa = clr_r;
      end
      FSM_EXEC: begin
        if (action_r) begin
          if (bad_free) begin
            res_slot_nxt   = '0;
            res_status_nxt = ST_BAD_FREE;
          end else begin
            used_we        = 1'b1;
            time_we        = 1'b1;
            res_slot_nxt   = idx_r;
            res_status_nxt = ST_FREED;
          end
        end else begin
          // issue the first read of the scan
          rd_addr     = first_slot_r;
          chk_vld_nxt = ({1'b0, first_slot_r} < mark);
          chk_idx_nxt = first_slot_r;
          scan_nxt    = {1'b0, first_slot_r} + MARK_W'(1);
        end
      end
      FSM_SCAN: begin
        if (hit) begin
          used_we        = 1'b1;
          used_wa        = chk_idx_r;
          used_wd        = 1'b1;
          res_slot_nxt   = chk_idx_r;
          res_status_nxt = ST_REUSED;
        end else if (scan_r < mark) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_r[SLOT_W-1:0];
          scan_nxt    = scan_r + MARK_W'(1);
        end
      end
      FSM_GROW: begin
        if (table_full) begin
          res_slot_nxt   = '0;
          res_status_nxt = ST_FULL;
        end else begin
          used_we        = 1'b1;
          used_wa        = mark[SLOT_W-1:0];
          used_wd        = 1'b1;
          high_water_nxt = mark + MARK_W'(1);
          res_slot_nxt   = mark[SLOT_W-1:0];
          res_status_nxt = ST_NEW;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FSM_CLEAR;
      clr_r        <= '0;
      high_water_r <= '0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      high_water_r <= high_water_nxt;
      chk_vld_r    <= chk_vld_nxt;
      if (state_r == FSM_CLEAR) clr_r <= clr_r + SLOT_W'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    chk_idx_r    <= chk_idx_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    if (in_acc) begin
      action_r <= in_action;
      idx_r    <= in_slot_index;
      frame_r  <= in_frame;
    end
    if (out_load) begin
      out_slot_r   <= res_slot_r;
      out_status_r <= res_status_r;
    end
  end

  // used-bit table: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    used_q_r <= used_mem[rd_addr];
  end

  // free-time table, written only by a free
  always_ff @(posedge clk) begin
    if (time_we) time_mem[idx_r] <= frame_r;
    time_q_r <= time_mem[rd_addr];
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

  // high-water mark never passes the table size
  a_hw_bound: assert property (@(posedge clk) disable iff (!rst_n)
    high_water_r <= MARK_W'(SLOTS))
    else $error("high-water mark beyond table");

  // high-water mark only grows
  a_hw_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> high_water_r >= $past(high_water_r))
    else $error("high-water mark went down");

  // a reused slot lies inside the allocatable range
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_SCAN && hit) |->
      (chk_idx_r >= first_slot_r && {1'b0, chk_idx_r} < mark))
    else $error("reuse outside scan range");

  // a new result only comes from the result state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == FSM_RESULT)
    else $error("result loaded outside result state");

endmodule
